/* design/crt_pkg.sv */
// Package for the circular run tracker: ring depth, operation codes and
// the control bundle that drives the row of occupancy cells.
// No dependencies.
`default_nettype none
package crt_pkg;
    localparam int RING_N = 1024;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;

    localparam logic [1:0] FUNC_QUERY  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_REINIT = 2'd3;

    localparam logic [LEN_W-1:0] SIZE_MIN = 11'd2;
    localparam logic [LEN_W-1:0] SIZE_MAX = 11'd1024;

    typedef struct packed {
        logic             shift;
        logic             init;
        logic             fill;
        logic [LEN_W-1:0] ring_size;
    } cell_ctrl_t;
endpackage
`default_nettype wire

/* design/crt_cell.sv */
// One occupancy cell of the ring row. Holds one bit; shifts towards
// cell 0 and takes the wrapped head bit when it is the last live cell.
// Depends on crt_pkg.
`default_nettype none
module crt_cell #(
    parameter int IDX = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  crt_pkg::cell_ctrl_t ctrl,
    input  wire                 next_bit,
    input  wire                 wrap_bit,
    output logic                occ
);
    import crt_pkg::*;

    logic occ_reg;
    logic occ_next;
    logic in_ring;
    logic is_last;

    assign in_ring = LEN_W'(IDX) < ctrl.ring_size;
    assign is_last = LEN_W'(IDX) == (ctrl.ring_size - 11'd1);

    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.init)
        begin
            occ_next = ctrl.fill & in_ring;
        end
        else if (ctrl.shift && in_ring)
        begin
            // hand over from the neighbour; the last live cell takes the head
            occ_next = is_last ? wrap_bit : next_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign occ = occ_reg;
endmodule
`default_nettype wire

/* design/circular_run_tracker.sv */
// Circular run tracker top level: row of occupancy cells plus the scan
// controller that walks one revolution of the ring per operation.
// Depends on crt_pkg and crt_cell.
//
// Usage:
//   Command channel: drive func, position and fill with start high; the
//   beat is taken at a clock edge where start is high and busy is low.
//   busy stays high until the result beat is presented on the result ports.
//   Result channel: done is high for exactly one cycle with occupied,
//   run_start, run_length, ring_full and out_of_range valid. The receiver
//   cannot stall; the beat is lost if it is not captured then.
//   Configuration: cfg_write with cfg_wdata sets ring_size (saturated to
//   2..1024) at that edge; write only while busy is low.
//   Sequencing: after the accepting edge the controller scans the ring, then
//   passes through a report state, and done is registered from it; the next
//   beat can be taken at the edge that ends the done cycle. The scan is set
//   by the cell row, which rotates the ring one position per cycle past cell 0
//   for one whole revolution; the head of the row is where inserts and deletes
//   land and where the run of the position is measured.
//   Reset: every position is free and ring_size is 1024. Changing ring_size
//   leaves the occupancy of positions beyond it untouched.
`default_nettype none
module circular_run_tracker (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire  [1:0]                 func,
    input  wire  [crt_pkg::POS_W-1:0]  position,
    input  wire                        fill,
    input  wire                        cfg_write,
    input  wire  [crt_pkg::LEN_W-1:0]  cfg_wdata,
    output logic                       done,
    output logic                       occupied,
    output logic [crt_pkg::POS_W-1:0]  run_start,
    output logic [crt_pkg::LEN_W-1:0]  run_length,
    output logic                       ring_full,
    output logic                       out_of_range
);
    import crt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] ring_size_reg, ring_size_next;
    logic [1:0]       func_reg;
    logic [POS_W-1:0] pos_reg;
    logic             oor_reg;
    logic [POS_W-1:0] cnt_reg, cnt_next;

    // run bookkeeping along the revolution
    logic             all_occ_reg, all_occ_next;
    logic             pre_open_reg, pre_open_next;
    logic [LEN_W-1:0] pre_len_reg, pre_len_next;
    logic [POS_W-1:0] cur_start_reg, cur_start_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic             found_reg, found_next;
    logic             pos_occ_reg, pos_occ_next;
    logic             pos_pre_reg, pos_pre_next;
    logic             pos_done_reg, pos_done_next;
    logic [POS_W-1:0] pos_start_reg, pos_start_next;
    logic [LEN_W-1:0] pos_len_reg, pos_len_next;

    logic             done_reg, done_next;
    logic             occ_o_reg, occ_o_next;
    logic [POS_W-1:0] start_o_reg, start_o_next;
    logic [LEN_W-1:0] len_o_reg, len_o_next;
    logic             full_o_reg, full_o_next;
    logic             oor_o_reg, oor_o_next;

    logic             accept;
    logic             head_bit;
    logic             hit;
    logic             last;
    logic             cur_open;
    logic [LEN_W-1:0] cfg_sat;
    cell_ctrl_t       ctrl;
    logic [RING_N-1:0] occ_w;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign ctrl.shift     = (state_reg == S_SCAN);
    assign ctrl.init      = accept && (func == FUNC_REINIT);
    assign ctrl.fill      = fill;
    assign ctrl.ring_size = ring_size_reg;

    assign hit  = (cnt_reg == pos_reg);
    assign last = ({1'b0, cnt_reg} == (ring_size_reg - 11'd1));

    // modify the head as it passes: insert or delete lands here
    always_comb
    begin
        head_bit = occ_w[0];
        if (hit && !oor_reg)
        begin
            if (func_reg == FUNC_INSERT)
            begin
                head_bit = 1'b1;
            end
            else if (func_reg == FUNC_DELETE)
            begin
                head_bit = 1'b0;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < RING_N; k++)
        begin : g_cell
            crt_cell #(.IDX(k)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .next_bit (occ_w[(k + 1) % RING_N]),
                .wrap_bit (head_bit),
                .occ      (occ_w[k])
            );
        end
    endgenerate

    // saturate configuration writes to the legal size range
    always_comb
    begin
        cfg_sat = cfg_wdata;
        if (cfg_wdata < SIZE_MIN)
        begin
            cfg_sat = SIZE_MIN;
        end
        else if (cfg_wdata > SIZE_MAX)
        begin
            cfg_sat = SIZE_MAX;
        end
        ring_size_next = cfg_write ? cfg_sat : ring_size_reg;
    end

    assign cur_open = (cur_len_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        all_occ_next   = all_occ_reg;
        pre_open_next  = pre_open_reg;
        pre_len_next   = pre_len_reg;
        cur_start_next = cur_start_reg;
        cur_len_next   = cur_len_reg;
        found_next     = found_reg;
        pos_occ_next   = pos_occ_reg;
        pos_pre_next   = pos_pre_reg;
        pos_done_next  = pos_done_reg;
        pos_start_next = pos_start_reg;
        pos_len_next   = pos_len_reg;
        done_next      = 1'b0;
        occ_o_next     = occ_o_reg;
        start_o_next   = start_o_reg;
        len_o_next     = len_o_reg;
        full_o_next    = full_o_reg;
        oor_o_next     = oor_o_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_SCAN;
                    cnt_next      = '0;
                    all_occ_next  = 1'b1;
                    pre_open_next = 1'b1;
                    pre_len_next  = '0;
                    cur_len_next  = '0;
                    found_next    = 1'b0;
                    pos_occ_next  = 1'b0;
                    pos_pre_next  = 1'b0;
                    pos_done_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 10'd1;
                if (head_bit)
                begin
                    if (!cur_open)
                    begin
                        cur_start_next = cnt_reg;
                    end
                    cur_len_next = cur_len_reg + 11'd1;
                end
                else
                begin
                    cur_len_next = '0;
                    all_occ_next = 1'b0;
                end
                if (pre_open_reg && head_bit)
                begin
                    pre_len_next = pre_len_reg + 11'd1;
                end
                else
                begin
                    pre_open_next = 1'b0;
                end
                if (hit)
                begin
                    found_next     = 1'b1;
                    pos_occ_next   = head_bit;
                    pos_pre_next   = pre_open_reg && head_bit;
                    pos_start_next = cur_open ? cur_start_reg : cnt_reg;
                end
                // close the run of the position when it ends mid ring
                if (found_reg && pos_occ_reg && !pos_done_reg && !head_bit)
                begin
                    pos_done_next = 1'b1;
                    pos_len_next  = cur_len_reg;
                end
                if (last)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                state_next   = S_IDLE;
                done_next    = 1'b1;
                full_o_next  = all_occ_reg;
                oor_o_next   = oor_reg;
                occ_o_next   = 1'b0;
                start_o_next = '0;
                len_o_next   = '0;
                if (!oor_reg && pos_occ_reg)
                begin
                    occ_o_next = 1'b1;
                    if (all_occ_reg)
                    begin
                        len_o_next = ring_size_reg;
                    end
                    else if (pos_pre_reg)
                    begin
                        // run through position 0 may join the tail run
                        start_o_next = cur_open ? cur_start_reg : '0;
                        len_o_next   = pre_len_reg + (cur_open ? cur_len_reg : '0);
                    end
                    else if (pos_done_reg)
                    begin
                        start_o_next = pos_start_reg;
                        len_o_next   = pos_len_reg;
                    end
                    else
                    begin
                        start_o_next = pos_start_reg;
                        len_o_next   = cur_len_reg + pre_len_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ring_size_reg <= SIZE_MAX;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_size_reg <= ring_size_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            pos_reg  <= position;
            oor_reg  <= ({1'b0, position} >= ring_size_reg);
        end
        cnt_reg       <= cnt_next;
        all_occ_reg   <= all_occ_next;
        pre_open_reg  <= pre_open_next;
        pre_len_reg   <= pre_len_next;
        cur_start_reg <= cur_start_next;
        cur_len_reg   <= cur_len_next;
        found_reg     <= found_next;
        pos_occ_reg   <= pos_occ_next;
        pos_pre_reg   <= pos_pre_next;
        pos_done_reg  <= pos_done_next;
        pos_start_reg <= pos_start_next;
        pos_len_reg   <= pos_len_next;
        occ_o_reg     <= occ_o_next;
        start_o_reg   <= start_o_next;
        len_o_reg     <= len_o_next;
        full_o_reg    <= full_o_next;
        oor_o_reg     <= oor_o_next;
    end

    assign done         = done_reg;
    assign occupied     = occ_o_reg;
    assign run_start    = start_o_reg;
    assign run_length   = len_o_reg;
    assign ring_full    = full_o_reg;
    assign out_of_range = oor_o_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result beat while busy");
    a_oor_free: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> !occupied) else $error("out of range yet occupied");
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && occupied |-> run_length != '0) else $error("empty run reported");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> {1'b0, cnt_reg} < ring_size_reg)
        else $error("scan ran past the ring");
endmodule
`default_nettype wire
